// ===== hdl/lbp3_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp3_pkg
// Shared widths, register indexes, request kinds and the rotation helper
// for the 3x3 binary pattern window coder.
// ----------------------------------------------------------------------------
package lbp3_pkg;

  // default line length the line stores are sized for
  localparam int MAX_WIDTH_DEF = 1024;

  // field widths
  localparam int PIXEL_W   = 8;
  localparam int CODE_W    = 8;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 16;

  // output item packing: code, row, col, zero pad to whole bytes
  localparam int OUT_BITS    = CODE_W + ROW_W + COL_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 2'd2;

  // register reset values
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

  // request kinds on the input tuser bit
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // output queue
  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);

  typedef struct packed {
    logic              last;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CODE_W-1:0] code;
  } out_item_t;

  // smallest value over the eight circular rotations of a code
  function automatic logic [CODE_W-1:0] rotate_min(input logic [CODE_W-1:0] v);
    logic [CODE_W-1:0] best;
    logic [CODE_W-1:0] cur;
    best = v;
    cur  = v;
    for (int k = 0; k < CODE_W; k++) begin
      cur = {cur[0], cur[CODE_W-1:1]};
      if (cur < best) best = cur;
    end
    return best;
  endfunction

endpackage

// ===== hdl/lbp_3x3_window_coder.sv =====
// ----------------------------------------------------------------------------
// lbp_3x3_window_coder
// 3x3 local binary pattern coder on a raster pixel stream, with two line
// stores in block memory, a 3x3 window and an optional rotation-invariant code.
// ----------------------------------------------------------------------------
//
//  port group  | dir | payload
//  ------------+-----+--------------------------------------------------------
//  s_axis      | in  | tdata = pixel, tuser = req_type (1 = flush)
//  m_axis      | out | tdata = code, row, col; tlast = frame_end
//  cfg         | in  | cfg_index selects register, cfg_data is the value
//
//  One item is taken per clock while s_axis_tready is high.
//  Rate is set by the line store memories: one read at stage 0 and one write
//  at stage 1 per item, with forwarding when back-to-back items hit one entry.
//  A four-entry output queue with credit counting decouples the two sides;
//  s_axis_tready drops only during reset or while results wait in that queue.
//  Reset is synchronous; line stores are not cleared (no clearing pass).
//
module lbp_3x3_window_coder #(
  parameter int MAX_WIDTH = lbp3_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // pixel input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [lbp3_pkg::PIXEL_W-1:0]        s_axis_tdata,   // [7:0] pixel
  input  logic                                s_axis_tuser,   // [0] req_type
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lbp3_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [7:0] code, [23:8] row,
                                                              // [33:24] col, rest zero
  output logic                                m_axis_tlast,   // frame_end
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbp3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lbp3_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int IRW = lbp3_pkg::ROW_W + 1;

  // configuration registers
  logic [lbp3_pkg::IMG_W_W-1:0] image_width;
  logic [lbp3_pkg::IMG_H_W-1:0] image_height;
  logic                         rotation_invariant;

  // position counters
  logic [AW-1:0]                in_col;
  logic [IRW-1:0]               in_row;
  logic [AW-1:0]                out_col;
  logic [lbp3_pkg::ROW_W-1:0]   out_row;

  // line stores
  logic [lbp3_pkg::PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
  logic [lbp3_pkg::PIXEL_W-1:0] middle_mem [MAX_WIDTH];
  logic [lbp3_pkg::PIXEL_W-1:0] upper_rd;
  logic [lbp3_pkg::PIXEL_W-1:0] middle_rd;

  // forwarding of the write that overlaps a read
  logic                         fwd;
  logic [lbp3_pkg::PIXEL_W-1:0] fwd_top;
  logic [lbp3_pkg::PIXEL_W-1:0] fwd_mid;

  // stage 1
  logic                         s1_valid;
  logic [AW-1:0]                s1_addr;
  logic [lbp3_pkg::PIXEL_W-1:0] s1_px;
  logic                         s1_emit;
  logic                         s1_border;
  logic                         s1_last;
  logic [lbp3_pkg::ROW_W-1:0]   s1_row;
  logic [AW-1:0]                s1_col;
  logic [lbp3_pkg::PIXEL_W-1:0] s1_top;
  logic [lbp3_pkg::PIXEL_W-1:0] s1_mid;
  logic [lbp3_pkg::CODE_W-1:0]  s1_pat;

  // window
  logic [lbp3_pkg::PIXEL_W-1:0] win      [9];
  logic [lbp3_pkg::PIXEL_W-1:0] win_next [9];

  // stage 2
  logic                         s2_valid;
  logic [lbp3_pkg::CODE_W-1:0]  s2_pat;
  logic [lbp3_pkg::PIXEL_W-1:0] s2_center;
  logic                         s2_border;
  logic                         s2_last;
  logic [lbp3_pkg::ROW_W-1:0]   s2_row;
  logic [AW-1:0]                s2_col;
  logic [lbp3_pkg::CODE_W-1:0]  s2_code;

  // output queue
  lbp3_pkg::out_item_t          ofifo [lbp3_pkg::OFIFO_DEPTH];
  lbp3_pkg::out_item_t          ofifo_head;
  logic [lbp3_pkg::OFIFO_AW-1:0] wr_ptr;
  logic [lbp3_pkg::OFIFO_AW-1:0] rd_ptr;
  logic [lbp3_pkg::OFIFO_AW:0]   ocount;
  logic                          push;
  logic                          pop;

  // stage 0 signals
  logic [lbp3_pkg::IMG_W_W-1:0] eff_w;
  logic [lbp3_pkg::IMG_W_W-1:0] w_m1;
  logic [lbp3_pkg::IMG_H_W-1:0] eff_h;
  logic [lbp3_pkg::IMG_H_W-1:0] h_m1;
  logic                         accept;
  logic                         is_flush;
  logic                         frame_in;
  logic                         restart;
  logic                         enter;
  logic [AW-1:0]                cur_col;
  logic [IRW-1:0]               cur_row;
  logic [AW-1:0]                cur_ocol;
  logic [lbp3_pkg::ROW_W-1:0]   cur_orow;
  logic [lbp3_pkg::PIXEL_W-1:0] px;
  logic                         emit;
  logic                         col_wrap;
  logic                         ocol_wrap;
  logic                         o_border;
  logic                         o_last;
  logic [AW-1:0]                in_col_next;
  logic [IRW-1:0]               in_row_next;
  logic [AW-1:0]                out_col_next;
  logic [lbp3_pkg::ROW_W-1:0]   out_row_next;

  // configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= lbp3_pkg::IMAGE_WIDTH_RST;
      image_height       <= lbp3_pkg::IMAGE_HEIGHT_RST;
      rotation_invariant <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lbp3_pkg::REG_IMAGE_WIDTH:  image_width        <= cfg_data[lbp3_pkg::IMG_W_W-1:0];
        lbp3_pkg::REG_IMAGE_HEIGHT: image_height       <= cfg_data[lbp3_pkg::IMG_H_W-1:0];
        lbp3_pkg::REG_ROTATION:     rotation_invariant <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (image_width < 11'd3) begin
      eff_w = 11'd3;
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = lbp3_pkg::IMG_W_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height < 16'd3) ? 16'd3 : image_height;
    w_m1  = eff_w - 11'd1;
    h_m1  = eff_h - 16'd1;
  end

  // stage 0: request decode and position bookkeeping
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_flush = (s_axis_tuser == lbp3_pkg::REQ_FLUSH);
  assign frame_in = (in_row >= {1'b0, eff_h});
  assign restart  = !is_flush && frame_in;
  assign enter    = accept && !(is_flush && !frame_in);

  always_comb begin
    cur_col  = restart ? '0 : in_col;
    cur_row  = restart ? '0 : in_row;
    cur_ocol = restart ? '0 : out_col;
    cur_orow = restart ? '0 : out_row;
    px       = is_flush ? '0 : s_axis_tdata;

    emit      = (cur_row >= IRW'(2)) || (cur_row == IRW'(1) && cur_col != '0);
    col_wrap  = (32'(cur_col) + 32'd1 >= 32'(eff_w));
    ocol_wrap = (32'(cur_ocol) + 32'd1 >= 32'(eff_w));
    o_border  = (cur_orow == '0) || (cur_orow >= h_m1) || (cur_ocol == '0) ||
                (32'(cur_ocol) >= 32'(w_m1));
    o_last    = (cur_orow >= h_m1) && (32'(cur_ocol) >= 32'(w_m1));

    in_col_next  = col_wrap ? '0 : cur_col + AW'(1);
    in_row_next  = col_wrap ? cur_row + IRW'(1) : cur_row;
    out_col_next = cur_ocol;
    out_row_next = cur_orow;
    if (emit) begin
      if (o_last) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else if (ocol_wrap) begin
        out_col_next = '0;
        out_row_next = cur_orow + 16'd1;
      end else begin
        out_col_next = cur_ocol + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (enter) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // line store reads at stage 0, write back at stage 1
  always_ff @(posedge clk) begin
    if (enter) upper_rd <= upper_mem[cur_col];
    if (s1_valid) upper_mem[s1_addr] <= s1_mid;
  end

  always_ff @(posedge clk) begin
    if (enter) middle_rd <= middle_mem[cur_col];
    if (s1_valid) middle_mem[s1_addr] <= s1_px;
  end

  // catch a write to the entry being read in the same cycle
  always_ff @(posedge clk) begin
    if (enter) begin
      fwd     <= s1_valid && (s1_addr == cur_col);
      fwd_top <= s1_mid;
      fwd_mid <= s1_px;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= enter;
    end
    if (enter) begin
      s1_addr   <= cur_col;
      s1_px     <= px;
      s1_emit   <= emit;
      s1_border <= o_border;
      s1_last   <= o_last;
      s1_row    <= cur_orow;
      s1_col    <= cur_ocol;
    end
  end

  assign s1_top = fwd ? fwd_top : upper_rd;
  assign s1_mid = fwd ? fwd_mid : middle_rd;

  // window shift: columns move west, new column enters at east
  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = s1_top;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = s1_mid;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (s1_valid) begin
      for (int i = 0; i < 9; i++) win[i] <= win_next[i];
    end
  end

  // neighbour compares, bit 0 east then counter-clockwise
  always_comb begin
    s1_pat[0] = win_next[5] > win_next[4];
    s1_pat[1] = win_next[2] > win_next[4];
    s1_pat[2] = win_next[1] > win_next[4];
    s1_pat[3] = win_next[0] > win_next[4];
    s1_pat[4] = win_next[3] > win_next[4];
    s1_pat[5] = win_next[6] > win_next[4];
    s1_pat[6] = win_next[7] > win_next[4];
    s1_pat[7] = win_next[8] > win_next[4];
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
    if (s1_valid) begin
      s2_pat    <= s1_pat;
      s2_center <= win_next[4];
      s2_border <= s1_border;
      s2_last   <= s1_last;
      s2_row    <= s1_row;
      s2_col    <= s1_col;
    end
  end

  // final code selection
  always_comb begin
    if (s2_border) begin
      s2_code = rotation_invariant ? '0 : s2_center;
    end else if (rotation_invariant) begin
      s2_code = lbp3_pkg::rotate_min(s2_pat);
    end else begin
      s2_code = s2_pat;
    end
  end

  // output queue
  assign push = s2_valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      ofifo[wr_ptr].code <= s2_code;
      ofifo[wr_ptr].row  <= s2_row;
      ofifo[wr_ptr].col  <= lbp3_pkg::COL_W'(s2_col);
      ofifo[wr_ptr].last <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      ocount <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + lbp3_pkg::OFIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + lbp3_pkg::OFIFO_AW'(1);
      case ({push, pop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ;
      endcase
    end
  end

  assign ofifo_head    = ofifo[rd_ptr];
  assign m_axis_tvalid = (ocount != '0);
  assign m_axis_tdata  = {(lbp3_pkg::OUT_TDATA_W - lbp3_pkg::OUT_BITS)'(0),
                          ofifo_head.col, ofifo_head.row, ofifo_head.code};
  assign m_axis_tlast  = ofifo_head.last;

  // credit check: every item in flight has a queue slot waiting
  assign s_axis_tready = !rst &&
    ((4'(ocount) + 4'(s1_valid) + 4'(s2_valid)) < 4'(lbp3_pkg::OFIFO_DEPTH));

endmodule

// ===== hdl/lbp3_chk.sv =====
// ----------------------------------------------------------------------------
// lbp3_chk
// Port-level checks for the 3x3 binary pattern window coder, bound to the
// top level.
// ----------------------------------------------------------------------------
module lbp3_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lbp3_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // a result needs an item taken earlier, through stage 1, stage 2 and the queue
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("result appeared without an item three cycles before");

  // input stalls only while results wait at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // the frame end result sits at least at row 2, column 2
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tdata[23:8] >= 16'd2) && (m_axis_tdata[33:24] >= 10'd2))
    else $error("frame end at an impossible position");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind lbp_3x3_window_coder lbp3_chk u_lbp3_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
